// ----- rtl/sapq_pkg.sv -----
// Shared types and constants for the sorted array priority queue.
package sapq_pkg;

  localparam int VAL_W   = 32;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = VAL_W + PRIO_W;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_DEQ_RD,
    S_DEQ_HEAD,
    S_DEQ_MV,
    S_FIN
  } sapq_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch;
    logic rd;
    logic shift_wr;
    logic ins_wr;
    logic cap_head;
    logic load_out;
  } sapq_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_deq;
    logic reject;
    logic op_deq;
    logic ptr_zero;
    logic ptr_end;
    logic greater;
    logic out_busy;
  } sapq_sts_t;

endpackage

// ----- rtl/sorted_array_priority_queue.sv -----
// Top level of the sorted array priority queue.
//
// The input channel carries one operation per transaction: in_tuser selects
// enqueue (0) or dequeue (1), in_tdata carries the value and priority used by
// an enqueue. Every operation yields exactly one result transaction on the
// output channel with a status code in out_tuser and the removed entry and
// the occupancy after the operation in out_tdata.
// The store is a single-port memory that is walked one entry per step, each
// step being a registered read followed by a write. An enqueue moves every
// entry that the new entry passes on by one place, a dequeue walks all
// entries in the store and pulls them up, and a rejected operation goes
// straight to its result without touching the store. The block takes one
// operation at a time; the next is accepted in the cycle after the result is
// loaded into the output register, even if that result has not been taken yet.
// When the receiver stalls, the result holds in the output register and the
// next operation runs up to its own result, then waits until the register is
// free. Reset empties the queue at once; no clearing pass is needed since
// only entries below the count are ever read.
module sorted_array_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata fields from bit 0: item_value[31:0], item_priority[47:32]
  input  logic [sapq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser fields from bit 0: opcode[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata fields from bit 0: out_value[31:0], out_priority[47:32],
  // occupancy[52:48], zero fill[55:53]
  output logic [sapq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser fields from bit 0: status[1:0]
  output logic [sapq_pkg::STAT_W-1:0]       out_tuser
);

  sapq_pkg::sapq_cmd_t cmd;
  sapq_pkg::sapq_sts_t sts;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sapq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending output transaction");

  // One operation at a time: acceptance closes the input until the result.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second operation accepted while one is in flight");

  // A rejected operation never touches the store.
  a_reject_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.reject) |=> !(cmd.ins_wr || cmd.shift_wr))
    else $error("store written by a rejected operation");

  // A dequeue only shifts entries, it never inserts.
  a_deq_noins: assert property (@(posedge clk) disable iff (!rst_n)
    sts.op_deq |-> !cmd.ins_wr)
    else $error("insert issued during a dequeue");

endmodule

// ----- rtl/sapq_ctrl.sv -----
// Sequencer for the priority queue: walks the store one entry at a time.
module sapq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sapq_pkg::sapq_sts_t sts,
  output sapq_pkg::sapq_cmd_t cmd
);

  sapq_pkg::sapq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sapq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (sts.reject) state_nxt = sapq_pkg::S_FIN;
          else if (sts.in_deq) state_nxt = sapq_pkg::S_DEQ_RD;
          else state_nxt = sapq_pkg::S_ENQ_RD;
        end
      end
      sapq_pkg::S_ENQ_RD: begin
        state_nxt = sts.ptr_zero ? sapq_pkg::S_FIN : sapq_pkg::S_ENQ_CMP;
      end
      sapq_pkg::S_ENQ_CMP: begin
        state_nxt = sts.greater ? sapq_pkg::S_ENQ_RD : sapq_pkg::S_FIN;
      end
      sapq_pkg::S_DEQ_RD: begin
        if (sts.ptr_end) state_nxt = sapq_pkg::S_FIN;
        else if (sts.ptr_zero) state_nxt = sapq_pkg::S_DEQ_HEAD;
        else state_nxt = sapq_pkg::S_DEQ_MV;
      end
      sapq_pkg::S_DEQ_HEAD: state_nxt = sapq_pkg::S_DEQ_RD;
      sapq_pkg::S_DEQ_MV:   state_nxt = sapq_pkg::S_DEQ_RD;
      sapq_pkg::S_FIN: begin
        if (!sts.out_busy) state_nxt = sapq_pkg::S_IDLE;
      end
      default: state_nxt = sapq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      sapq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      sapq_pkg::S_ENQ_RD: begin
        if (sts.ptr_zero) cmd.ins_wr = 1'b1;
        else cmd.rd = 1'b1;
      end
      sapq_pkg::S_ENQ_CMP: begin
        if (sts.greater) cmd.shift_wr = 1'b1;
        else cmd.ins_wr = 1'b1;
      end
      sapq_pkg::S_DEQ_RD: begin
        cmd.rd = !sts.ptr_end;
      end
      sapq_pkg::S_DEQ_HEAD: cmd.cap_head = 1'b1;
      sapq_pkg::S_DEQ_MV:   cmd.shift_wr = 1'b1;
      sapq_pkg::S_FIN:      cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/sapq_dp.sv -----
// Datapath: entry store, item registers, pointer, count and output register.
module sapq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sapq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  sapq_pkg::sapq_cmd_t               cmd,
  output sapq_pkg::sapq_sts_t               sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sapq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [sapq_pkg::STAT_W-1:0]       out_tuser
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam int PAD_W = sapq_pkg::OUT_TDATA_W - sapq_pkg::ENTRY_W - sapq_pkg::OCC_W;

  logic [sapq_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [sapq_pkg::ENTRY_W-1:0] rd_data_r;

  logic                          op_r;
  logic [sapq_pkg::ENTRY_W-1:0]  item_r;
  logic [CW-1:0]                 ptr_r, ptr_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [sapq_pkg::STAT_W-1:0]   res_status_r;
  logic [sapq_pkg::ENTRY_W-1:0]  res_entry_r;

  logic                          out_valid_r;
  logic [sapq_pkg::STAT_W-1:0]   out_status_r;
  logic [sapq_pkg::ENTRY_W-1:0]  out_entry_r;
  logic [sapq_pkg::OCC_W-1:0]    out_occ_r;

  logic [CW-1:0]                 ptr_m1;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [sapq_pkg::ENTRY_W-1:0]  wr_data;
  logic                          wr_en;
  logic                          in_full, in_empty;
  logic [CW+sapq_pkg::OCC_W-1:0] occ_wide;

  assign ptr_m1   = ptr_r - ONE;
  assign in_full  = (count_r >= FULL);
  assign in_empty = (count_r == '0);

  // Enqueue looks at the entry just ahead of the hole; dequeue pulls entries up.
  assign rd_addr = (op_r == sapq_pkg::OP_DEQ) ? ptr_r[AW-1:0] : ptr_m1[AW-1:0];
  assign wr_addr = (cmd.shift_wr && op_r == sapq_pkg::OP_DEQ) ? ptr_m1[AW-1:0]
                                                               : ptr_r[AW-1:0];
  assign wr_data = cmd.ins_wr ? item_r : rd_data_r;
  assign wr_en   = cmd.ins_wr || cmd.shift_wr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.latch) begin
      ptr_nxt = (in_tuser == sapq_pkg::OP_DEQ) ? '0 : count_r;
    end else if (cmd.shift_wr || cmd.cap_head) begin
      ptr_nxt = (op_r == sapq_pkg::OP_DEQ) ? ptr_r + ONE : ptr_m1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.load_out && res_status_r == sapq_pkg::ST_DONE) begin
      count_nxt = (op_r == sapq_pkg::OP_DEQ) ? count_r - ONE : count_r + ONE;
    end
  end

  assign occ_wide = {{sapq_pkg::OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.latch) begin
      op_r        <= in_tuser;
      item_r      <= in_tdata[sapq_pkg::ENTRY_W-1:0];
      res_entry_r <= '0;
      if (in_tuser == sapq_pkg::OP_DEQ) begin
        res_status_r <= in_empty ? sapq_pkg::ST_EMPTY : sapq_pkg::ST_DONE;
      end else begin
        res_status_r <= in_full ? sapq_pkg::ST_FULL : sapq_pkg::ST_DONE;
      end
    end
    if (cmd.cap_head) res_entry_r <= rd_data_r;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_occ_r    <= occ_wide[sapq_pkg::OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Signed compare: the new entry passes only strictly lower priorities.
  assign sts.greater  = $signed(item_r[sapq_pkg::ENTRY_W-1:sapq_pkg::VAL_W]) >
                        $signed(rd_data_r[sapq_pkg::ENTRY_W-1:sapq_pkg::VAL_W]);
  assign sts.in_deq   = (in_tuser == sapq_pkg::OP_DEQ);
  assign sts.reject   = (in_tuser == sapq_pkg::OP_DEQ) ? in_empty : in_full;
  assign sts.op_deq   = (op_r == sapq_pkg::OP_DEQ);
  assign sts.ptr_zero = (ptr_r == '0);
  assign sts.ptr_end  = (ptr_r >= count_r);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_occ_r, out_entry_r};

endmodule
